>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the TFTP write sequencer.
// No dependencies; bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/tftpw_pkg.sv
// Shared types and constants for the TFTP write sequencer.
// No dependencies; imported by tftpw_engine and the top level.
package tftpw_pkg;

  localparam int DEFAULT_MAX_BLOCK_SIZE = 1456;
  localparam int BASE_BLOCK_SIZE        = 512;
  localparam int MIN_BLOCK_SIZE         = 8;
  localparam int TIMEOUT_LIMIT          = 5;
  localparam int BLIND_TIMEOUT_LIMIT    = 3;
  localparam int SETUP_TIMEOUT_FACTOR   = 4;
  localparam logic [15:0] SERVER_PORT_RESET = 16'd69;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIND_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT = 1'd1;

  localparam logic [15:0] OPC_RRQ   = 16'd1;
  localparam logic [15:0] OPC_WRQ   = 16'd2;
  localparam logic [15:0] OPC_DATA  = 16'd3;
  localparam logic [15:0] OPC_ACK   = 16'd4;
  localparam logic [15:0] OPC_ERROR = 16'd5;
  localparam logic [15:0] OPC_OACK  = 16'd6;

  localparam logic [7:0] TEXT_LOW  = 8'h20;
  localparam logic [7:0] TEXT_HIGH = 8'h7E;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PACKET  = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_DATA    = 2'd1,
    ACT_DONE    = 2'd2,
    ACT_FAILED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    FAIL_NONE        = 3'd0,
    FAIL_SERVER      = 3'd1,
    FAIL_TEXT        = 3'd2,
    FAIL_INVALID     = 3'd3,
    FAIL_BLKSIZE     = 3'd4,
    FAIL_TOO_MANY    = 3'd5,
    FAIL_TIMEOUT     = 3'd6
  } fail_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] rx_opcode;
    logic [15:0] rx_block;
    logic [15:0] rx_port;
    logic        blksize_present;
    logic [15:0] blksize_value;
    logic [15:0] source_bytes;
  } tftpw_item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] block_number;
    logic [15:0] dest_port;
    fail_t       fail_code;
    logic [31:0] total_bytes;
    logic        rollover_warning;
  } tftpw_result_t;

endpackage

>>> rtl/core/tftpw_engine.sv
// Transfer state and per-event decision logic of the TFTP write sequencer.
// Depends on tftpw_pkg; one event is applied per cycle when fire is high.
module tftpw_engine
  import tftpw_pkg::*;
#(
  parameter int MAX_BLOCK_SIZE = DEFAULT_MAX_BLOCK_SIZE,
  localparam int LenW = $clog2(MAX_BLOCK_SIZE + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tftpw_item_t      item,
  input  logic             blind_mode,
  input  logic [15:0]      server_port,
  output logic             res_valid,
  output tftpw_result_t    res,
  output logic [LenW-1:0]  res_length
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE,
    PH_DONE,
    PH_FAILED
  } phase_t;

  phase_t           phase, phase_next;
  logic [15:0]      block_count, block_count_next;
  logic [LenW-1:0]  block_size, block_size_next;
  logic [LenW-1:0]  previous_length, previous_length_next;
  logic             previous_valid, previous_valid_next;
  logic [4:0]       timeout_count, timeout_count_next;
  logic [2:0]       error_count, error_count_next;
  logic             rollover_seen, rollover_seen_next;
  logic [15:0]      target_port, target_port_next;
  logic [31:0]      byte_total, byte_total_next;
  logic             last_sent_kind, last_sent_kind_next;
  logic [LenW-1:0]  last_sent_length, last_sent_length_next;

  logic             is_oack_size;
  logic [LenW-1:0]  bs_use;
  logic [15:0]      bc_inc;
  logic             adv_roll;
  logic [LenW-1:0]  adv_len;
  logic             adv_done;
  logic [32:0]      adv_sum;
  logic [31:0]      adv_total;
  logic [7:0]       opc_high;
  logic             text_err;
  logic             bs_bad;
  logic [4:0]       tc_inc;
  logic [4:0]       limit;
  logic [4:0]       setup_limit;
  logic             resend;
  logic [2:0]       ec_inc;

  assign is_oack_size = (item.operation == OP_PACKET) && (item.rx_opcode == OPC_OACK) &&
                        item.blksize_present;
  assign bs_use    = is_oack_size ? item.blksize_value[LenW-1:0] : block_size;
  assign bc_inc    = block_count + 16'd1;
  assign adv_roll  = (bc_inc == 16'd0) && !rollover_seen;
  assign adv_len   = (item.source_bytes < 16'(bs_use)) ? item.source_bytes[LenW-1:0] : bs_use;
  assign adv_done  = (adv_len == '0) && previous_valid && (previous_length != bs_use);
  assign adv_sum   = {1'b0, byte_total} + 33'(adv_len);
  assign adv_total = adv_sum[32] ? '1 : adv_sum[31:0];

  assign opc_high    = item.rx_opcode[15:8];
  assign text_err    = (opc_high >= TEXT_LOW) && (opc_high <= TEXT_HIGH);
  assign bs_bad      = (item.blksize_value < 16'(MIN_BLOCK_SIZE)) ||
                       (item.blksize_value > 16'(MAX_BLOCK_SIZE));
  assign tc_inc      = timeout_count + 5'd1;
  assign limit       = blind_mode ? 5'(BLIND_TIMEOUT_LIMIT) : 5'(TIMEOUT_LIMIT);
  assign setup_limit = blind_mode ? 5'(BLIND_TIMEOUT_LIMIT * SETUP_TIMEOUT_FACTOR)
                                  : 5'(TIMEOUT_LIMIT * SETUP_TIMEOUT_FACTOR);
  assign resend      = (tc_inc < limit) || ((block_count == 16'd0) && (tc_inc < setup_limit));
  assign ec_inc      = error_count + 3'd1;

  always_comb begin
    logic do_advance;
    logic do_fail;
    fail_t code;

    phase_next            = phase;
    block_count_next      = block_count;
    block_size_next       = block_size;
    previous_length_next  = previous_length;
    previous_valid_next   = previous_valid;
    timeout_count_next    = timeout_count;
    error_count_next      = error_count;
    rollover_seen_next    = rollover_seen;
    target_port_next      = target_port;
    byte_total_next       = byte_total;
    last_sent_kind_next   = last_sent_kind;
    last_sent_length_next = last_sent_length;

    do_advance             = 1'b0;
    do_fail                = 1'b0;
    code                   = FAIL_NONE;
    res_valid              = 1'b0;
    res.action             = ACT_REQUEST;
    res.fail_code          = FAIL_NONE;
    res.rollover_warning   = 1'b0;
    res_length             = '0;

    if (fire) begin
      if (item.operation == OP_START) begin
        phase_next            = PH_ACTIVE;
        block_count_next      = 16'd0;
        block_size_next       = LenW'(BASE_BLOCK_SIZE);
        previous_length_next  = '0;
        previous_valid_next   = 1'b0;
        timeout_count_next    = 5'd1;
        error_count_next      = 3'd0;
        rollover_seen_next    = 1'b0;
        target_port_next      = server_port;
        byte_total_next       = 32'd0;
        last_sent_kind_next   = 1'b0;
        last_sent_length_next = '0;
        res_valid             = 1'b1;
      end else if (phase == PH_ACTIVE) begin
        case (item.operation)
          OP_TIMEOUT: begin
            timeout_count_next = tc_inc;
            if (resend) begin
              res_valid = 1'b1;
              if (last_sent_kind) begin
                res.action = ACT_DATA;
                res_length = last_sent_length;
              end
            end else if (blind_mode) begin
              timeout_count_next = 5'd0;
              do_advance         = 1'b1;
            end else begin
              do_fail = 1'b1;
              code    = FAIL_TIMEOUT;
            end
          end
          OP_PACKET: begin
            if (item.rx_opcode == OPC_ERROR) begin
              do_fail = 1'b1;
              code    = FAIL_SERVER;
            end else if (text_err) begin
              do_fail = 1'b1;
              code    = FAIL_TEXT;
            end else if ((item.rx_opcode == 16'd0) || (item.rx_opcode > OPC_OACK)) begin
              do_fail = 1'b1;
              code    = FAIL_INVALID;
            end else begin
              timeout_count_next = 5'd0;
              if ((block_count == 16'd0) && (item.rx_port != server_port)) begin
                target_port_next = item.rx_port;
              end
              if (item.rx_opcode == OPC_ACK) begin
                if (item.rx_block == block_count) begin
                  do_advance = 1'b1;
                end else if (item.rx_block > block_count) begin
                  error_count_next = ec_inc;
                  if (ec_inc > 3'd5) begin
                    do_fail = 1'b1;
                    code    = FAIL_TOO_MANY;
                  end
                end
              end else if (item.rx_opcode == OPC_OACK) begin
                if (item.blksize_present && bs_bad) begin
                  do_fail = 1'b1;
                  code    = FAIL_BLKSIZE;
                end else begin
                  block_size_next = bs_use;
                  do_advance      = (block_count == 16'd0);
                end
              end
            end
          end
          default: begin
          end
        endcase

        if (do_fail) begin
          phase_next    = PH_FAILED;
          res_valid     = 1'b1;
          res.action    = ACT_FAILED;
          res.fail_code = code;
        end else if (do_advance) begin
          res_valid            = 1'b1;
          block_count_next     = bc_inc;
          res.rollover_warning = adv_roll;
          if (adv_roll) begin
            rollover_seen_next = 1'b1;
          end
          if (adv_done) begin
            phase_next = PH_DONE;
            res.action = ACT_DONE;
          end else begin
            previous_length_next  = adv_len;
            previous_valid_next   = 1'b1;
            byte_total_next       = adv_total;
            last_sent_kind_next   = 1'b1;
            last_sent_length_next = adv_len;
            res.action            = ACT_DATA;
            res_length            = adv_len;
          end
        end
      end
    end

    res.block_number = block_count_next;
    res.dest_port    = target_port_next;
    res.total_bytes  = byte_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      block_count      <= 16'd0;
      block_size       <= LenW'(BASE_BLOCK_SIZE);
      previous_length  <= '0;
      previous_valid   <= 1'b0;
      timeout_count    <= 5'd1;
      error_count      <= 3'd0;
      rollover_seen    <= 1'b0;
      target_port      <= SERVER_PORT_RESET;
      byte_total       <= 32'd0;
      last_sent_kind   <= 1'b0;
      last_sent_length <= '0;
    end else begin
      phase            <= phase_next;
      block_count      <= block_count_next;
      block_size       <= block_size_next;
      previous_length  <= previous_length_next;
      previous_valid   <= previous_valid_next;
      timeout_count    <= timeout_count_next;
      error_count      <= error_count_next;
      rollover_seen    <= rollover_seen_next;
      target_port      <= target_port_next;
      byte_total       <= byte_total_next;
      last_sent_kind   <= last_sent_kind_next;
      last_sent_length <= last_sent_length_next;
    end
  end

endmodule

>>> rtl/core/tftp_write_client_sequencer_unit.sv
// Top level of the TFTP write client sequencer: input beat register, engine, output skid.
// Depends on tftpw_pkg, tftpw_engine and assert_macros.svh.
//
// Usage: the host sends one event beat per in_valid/in_ready handshake (start, received
// packet fields, or receive timeout). Each event gives zero or one result beat on the
// out_valid/out_ready channel: send request, send data block, done, or failed with a code.
// Configuration (blind_mode, server_port) is to be written on the cfg channel only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high.
// Path: an accepted event is held in the input register, and its result is then held in the
// result register. Throughput: one event per cycle while in_ready is high, set by the engine that
// applies each event to the transfer state.
// Stall: a two-entry output (result register plus skid) keeps taking events until both
// entries are full; in_ready then drops until the receiver takes a beat.
// Reset: synchronous; clears the transfer to idle, blind_mode to 0, server_port to 69,
// and empties the input register and output buffer.
`include "assert_macros.svh"

module tftp_write_client_sequencer_unit
  import tftpw_pkg::*;
#(
  parameter int MAX_BLOCK_SIZE = DEFAULT_MAX_BLOCK_SIZE,
  localparam int LenW = $clog2(MAX_BLOCK_SIZE + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [15:0]          rx_opcode,
  input  logic [15:0]          rx_block,
  input  logic [15:0]          rx_port,
  input  logic                 blksize_present,
  input  logic [15:0]          blksize_value,
  input  logic [15:0]          source_bytes,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           action,
  output logic [15:0]          block_number,
  output logic [LenW-1:0]      data_length,
  output logic [15:0]          dest_port,
  output logic [2:0]           fail_code,
  output logic [31:0]          total_bytes,
  output logic                 rollover_warning,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic             blind_mode;
  logic [15:0]      server_port;

  logic             s1_valid;
  tftpw_item_t      s1_item;
  logic             s1_go;

  logic             res_valid;
  tftpw_result_t    res;
  logic [LenW-1:0]  res_length;

  tftpw_result_t    out_res;
  logic [LenW-1:0]  out_length;
  logic             skid_valid;
  tftpw_result_t    skid_res;
  logic [LenW-1:0]  skid_length;
  logic             out_stall;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid && !skid_valid;
  assign in_ready  = !s1_valid || s1_go;
  assign out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blind_mode  <= 1'b0;
      server_port <= SERVER_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLIND_MODE:  blind_mode  <= cfg_data[0];
        CFG_SERVER_PORT: server_port <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (res_valid && !out_stall) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= skid_valid;
      end
      if (res_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= '{operation:       operation,
                   rx_opcode:       rx_opcode,
                   rx_block:        rx_block,
                   rx_port:         rx_port,
                   blksize_present: blksize_present,
                   blksize_value:   blksize_value,
                   source_bytes:    source_bytes};
    end
    if (res_valid && !out_stall) begin
      out_res    <= res;
      out_length <= res_length;
    end else if (out_valid && out_ready && skid_valid) begin
      out_res    <= skid_res;
      out_length <= skid_length;
    end
    if (res_valid && out_stall) begin
      skid_res    <= res;
      skid_length <= res_length;
    end
  end

  tftpw_engine #(
    .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_go),
    .item       (s1_item),
    .blind_mode (blind_mode),
    .server_port(server_port),
    .res_valid  (res_valid),
    .res        (res),
    .res_length (res_length)
  );

  assign action           = out_res.action;
  assign block_number     = out_res.block_number;
  assign data_length      = out_length;
  assign dest_port        = out_res.dest_port;
  assign fail_code        = out_res.fail_code;
  assign total_bytes      = out_res.total_bytes;
  assign rollover_warning = out_res.rollover_warning;

  `ASSERT_IMPLIES(a_skid_behind_head, clk, rst, skid_valid, out_valid, "skid full with empty output")
  `ASSERT_IMPLIES(a_fail_has_code, clk, rst, out_valid && (action == ACT_FAILED), fail_code != FAIL_NONE, "failure beat without code")
  `ASSERT_IMPLIES(a_len_capped, clk, rst, out_valid, data_length <= LenW'(MAX_BLOCK_SIZE), "data length above block size cap")

endmodule
